FILE: rtl/sha1s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_pkg
// Types, constants and round functions shared by the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int BLOCK_BITS  = 512;
  localparam int ROUNDS      = 80;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // iv[0] is h0
  localparam logic [4:0][31:0] IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } result_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_BYTE_END,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FOLD,
    BK_PAD,
    BK_EMIT
  } back_state_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

FILE: rtl/sha1s_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_front
// Input side: takes items, sorts them by kind and queues them for the core.
// ----------------------------------------------------------------------------
module sha1s_front #(
  parameter int DEPTH = sha1s_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sha1s_pkg::item_t  item,
  output logic              q_valid,
  input  logic              q_ready,
  output sha1s_pkg::entry_t q_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sha1s_pkg::entry_t slots [DEPTH];
  sha1s_pkg::entry_t entry_in;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  // items with neither flag carry no work and are dropped here
  assign item_ready = (count != CNT_W'(DEPTH));
  assign push       = item_valid && item_ready && (item.has_byte || item.end_of_message);
  assign q_valid    = (count != '0);
  assign pop        = q_valid && q_ready;
  assign q_entry    = slots[rd_ptr];

  always_comb begin
    entry_in.data = item.message_byte;
    if (item.has_byte && item.end_of_message) begin
      entry_in.kind = sha1s_pkg::KIND_BYTE_END;
    end else if (item.has_byte) begin
      entry_in.kind = sha1s_pkg::KIND_BYTE;
    end else begin
      entry_in.kind = sha1s_pkg::KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/sha1s_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_core
// Block buffer, padding sequencer, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1s_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  sha1s_pkg::entry_t  q_entry,
  output logic               digest_valid,
  input  logic               digest_ready,
  output sha1s_pkg::result_t digest
);

  localparam int BB = sha1s_pkg::BLOCK_BITS;

  sha1s_pkg::back_state_t state;
  sha1s_pkg::back_state_t state_next;

  logic [BB-1:0]     blk;
  logic [4:0][31:0]  h;
  logic [31:0]       a, b, c, d, e;
  logic [63:0]       bit_len;
  logic [5:0]        fill;
  logic [6:0]        rnd;
  logic [2:0]        word_idx;
  logic              closing;
  logic              marked;
  logic              len_done;
  logic              take;
  logic              out_load;

  logic [31:0]       w;
  logic [31:0]       w_mix;
  logic [31:0]       w_new;
  logic [31:0]       a_new;

  assign w     = blk[BB-1 -: 32];
  assign w_mix = blk[BB-1 -: 32] ^ blk[BB-65 -: 32] ^ blk[BB-257 -: 32] ^ blk[BB-417 -: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign a_new = {a[26:0], a[31:27]} + sha1s_pkg::round_f(rnd, b, c, d) + e
                 + sha1s_pkg::round_k(rnd) + w;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha1s_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            sha1s_pkg::KIND_BYTE:     state_next = (fill == 6'd63) ? sha1s_pkg::BK_ROUND
                                                                   : sha1s_pkg::BK_IDLE;
            sha1s_pkg::KIND_BYTE_END: state_next = (fill == 6'd63) ? sha1s_pkg::BK_ROUND
                                                                   : sha1s_pkg::BK_PAD;
            default:                  state_next = sha1s_pkg::BK_PAD;
          endcase
        end
      end
      sha1s_pkg::BK_ROUND: begin
        if (rnd == 7'(sha1s_pkg::ROUNDS - 1)) begin
          state_next = sha1s_pkg::BK_FOLD;
        end
      end
      sha1s_pkg::BK_FOLD: begin
        if (len_done) begin
          state_next = sha1s_pkg::BK_EMIT;
        end else if (closing) begin
          state_next = sha1s_pkg::BK_PAD;
        end else begin
          state_next = sha1s_pkg::BK_IDLE;
        end
      end
      sha1s_pkg::BK_PAD: begin
        if (marked && fill == 6'd56) begin
          state_next = sha1s_pkg::BK_ROUND;
        end else if (fill == 6'd63) begin
          state_next = sha1s_pkg::BK_ROUND;
        end
      end
      sha1s_pkg::BK_EMIT: begin
        if (out_load && word_idx == 3'd4) begin
          state_next = sha1s_pkg::BK_IDLE;
        end
      end
      default: state_next = sha1s_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready  = 1'b0;
    out_load = 1'b0;
    case (state)
      sha1s_pkg::BK_IDLE: q_ready  = 1'b1;
      sha1s_pkg::BK_EMIT: out_load = !digest_valid || digest_ready;
      default: begin
        q_ready  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign take = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1s_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // block buffer and round registers
  always_ff @(posedge clk) begin
    if (state_next == sha1s_pkg::BK_ROUND && state != sha1s_pkg::BK_ROUND) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == sha1s_pkg::BK_ROUND) begin
      a <= a_new;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    case (state)
      sha1s_pkg::BK_IDLE: begin
        if (take && q_entry.kind != sha1s_pkg::KIND_END) begin
          blk <= {blk[BB-9:0], q_entry.data};
        end
      end
      sha1s_pkg::BK_ROUND: blk <= {blk[BB-33:0], w_new};
      sha1s_pkg::BK_PAD: begin
        if (!marked) begin
          blk <= {blk[BB-9:0], sha1s_pkg::PAD_MARK};
        end else if (fill == 6'd56) begin
          blk <= {blk[BB-65:0], bit_len};
        end else begin
          blk <= {blk[BB-9:0], 8'h00};
        end
      end
      default: blk <= blk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h        <= sha1s_pkg::IV;
      bit_len  <= '0;
      fill     <= '0;
      rnd      <= '0;
      word_idx <= '0;
      closing  <= 1'b0;
      marked   <= 1'b0;
      len_done <= 1'b0;
    end else begin
      case (state)
        sha1s_pkg::BK_IDLE: begin
          if (take) begin
            if (q_entry.kind != sha1s_pkg::KIND_END) begin
              bit_len <= bit_len + 64'd8;
              fill    <= fill + 1'b1;
            end
            if (q_entry.kind != sha1s_pkg::KIND_BYTE) begin
              closing <= 1'b1;
            end
          end
          rnd <= '0;
        end
        sha1s_pkg::BK_ROUND: begin
          rnd <= rnd + 1'b1;
        end
        sha1s_pkg::BK_FOLD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          rnd  <= '0;
        end
        sha1s_pkg::BK_PAD: begin
          marked <= 1'b1;
          if (marked && fill == 6'd56) begin
            fill     <= '0;
            len_done <= 1'b1;
          end else begin
            fill <= fill + 1'b1;
          end
        end
        sha1s_pkg::BK_EMIT: begin
          if (out_load) begin
            if (word_idx == 3'd4) begin
              word_idx <= '0;
              h        <= sha1s_pkg::IV;
              bit_len  <= '0;
              fill     <= '0;
              closing  <= 1'b0;
              marked   <= 1'b0;
              len_done <= 1'b0;
            end else begin
              word_idx <= word_idx + 1'b1;
            end
          end
        end
        default: rnd <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (out_load) begin
      digest_valid <= 1'b1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest.digest_word <= h[word_idx];
      digest.last_word   <= (word_idx == 3'd4);
    end
  end

endmodule

FILE: rtl/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, digest out as five 32-bit words, h0 first.
// ----------------------------------------------------------------------------
// Each transaction on item carries at most one message byte; end_of_message
// closes the message, after which the block pads it and delivers five digest
// transactions (last_word marks h4), then starts over from the initial values.
// Items without a byte or end flag are dropped. A queue of QUEUE_DEPTH entries
// sits in front of the core. The core takes one byte per cycle while it is idle;
// it takes none while a full 64-byte block runs through the 80 rounds of the
// single round unit and is folded into the chaining value, nor while it pads
// or emits. Closing a message appends one padding byte at a time, with the
// 64-bit length shifted in as a whole; padding may fill a second block, and
// each padding block is compressed and folded in the same way.
// ----------------------------------------------------------------------------
module sha1_stream_hasher #(
  parameter int QUEUE_DEPTH = sha1s_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sha1s_pkg::item_t   item,
  output logic               digest_valid,
  input  logic               digest_ready,
  output sha1s_pkg::result_t digest
);

  logic              q_valid;
  logic              q_ready;
  sha1s_pkg::entry_t q_entry;

  sha1s_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  sha1s_core u_core (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_entry      (q_entry),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queue dropped a pending entry");

  a_queue_stable: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> $stable(q_entry))
    else $error("queue entry changed while stalled");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest.last_word |=> !(digest_valid && digest.last_word))
    else $error("last word repeated after acceptance");

endmodule
